/* design/lss_pkg.sv */
// lss_pkg: shared types and constants of the led strip frame serializer
// request kinds, color channel codes, store reset value and parameter defaults
// no dependencies
package lss_pkg;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_BEGIN    = 2'd0,
      REQ_SET      = 2'd1,
      REQ_COMPLETE = 2'd2,
      REQ_TICK     = 2'd3
   } req_kind_type;

   // color channel codes on the request side
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   // no color, a set pixel with this code writes nothing
   localparam logic [1:0] CH_NONE  = 2'd3;

   // slot offsets inside a pixel, grb order
   localparam logic [1:0] SLOT_GREEN = 2'd0;
   localparam logic [1:0] SLOT_RED   = 2'd1;
   localparam logic [1:0] SLOT_BLUE  = 2'd2;

   localparam logic [7:0] STORE_RESET = 8'h80;
   localparam logic [7:0] LEVEL_MARK  = 8'h80;
   localparam logic [7:0] LATCH_BYTE  = 8'h00;

   // hard limit of bytes per transmit tick
   localparam int MaxOut = 8;

   localparam int DefPixels   = 64;
   localparam int DefLatchLen = 1;
   localparam int DefMaxBurst = 8;

   // control from the sequencer to the output register
   typedef struct packed {
      logic load;
      logic latch;
      logic run_last;
      logic frame_last;
   } out_load_type;

endpackage

/* design/lss_frame_mem.sv */
// lss_frame_mem: frame store, one write port and one read port
// read data is registered; depends on nothing
module lss_frame_mem #(
   parameter int DEPTH  = 192,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lss_ctrl.sv */
// lss_ctrl: request decode and stream sequencer of the frame serializer
// clears the store after reset, writes pixels, walks the stream on ticks
// depends on lss_pkg
module lss_ctrl
   import lss_pkg::*;
#(
   parameter int PIXELS    = DefPixels,
   parameter int LATCH_LEN = DefLatchLen,
   parameter int MAX_BURST = DefMaxBurst,
   parameter int ADDR_W    = $clog2(3 * PIXELS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_kind_type       req_kind,
   input  logic [15:0]        pixel_index,
   input  logic [1:0]         channel,
   input  logic [7:0]         level,
   input  logic [3:0]         tx_free,
   input  logic               out_busy,
   output out_load_type       out_load,
   output logic               wr_en,
   output logic [ADDR_W-1:0]  wr_addr,
   output logic [7:0]         wr_data,
   output logic               rd_en,
   output logic [ADDR_W-1:0]  rd_addr
);

   localparam int Slots     = 3 * PIXELS;
   localparam int StreamLen = Slots + LATCH_LEN;
   localparam int PosW      = $clog2(StreamLen + 1);
   localparam int PixW      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int BurstCap  = (MAX_BURST < MaxOut) ? MAX_BURST : MaxOut;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_LOAD
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [3:0]        remain_ff, remain_in;
   logic              updating_ff, updating_in;

   logic [PixW-1:0]   pix;
   logic [1:0]        slot;
   logic [ADDR_W-1:0] slot_addr;
   logic [3:0]        want;
   logic              pos_in_store;
   logic              pos_at_end;
   logic              stream_open;

   assign pix       = pixel_index[PixW-1:0];
   assign slot_addr = ADDR_W'({pix, 1'b0}) + ADDR_W'(pix) + ADDR_W'(slot);
   assign want      = (tx_free > 4'(BurstCap)) ? 4'(BurstCap) : tx_free;

   assign pos_in_store = (pos_ff < PosW'(Slots));
   assign pos_at_end   = (pos_ff == PosW'(StreamLen - 1));
   assign stream_open  = (pos_ff < PosW'(StreamLen));

   always_comb begin
      case (channel)
         CH_RED:   slot = SLOT_RED;
         CH_GREEN: slot = SLOT_GREEN;
         default:  slot = SLOT_BLUE;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      pos_in      = pos_ff;
      remain_in   = remain_ff;
      updating_in = updating_ff;
      req_ready   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = slot_addr;
      wr_data     = LEVEL_MARK | {1'b0, level[7:1]};
      rd_en       = 1'b0;
      rd_addr     = pos_ff[ADDR_W-1:0];
      out_load    = '0;

      case (state_ff)
         ST_CLEAR: begin
            // sweep the store to its reset value, one entry per cycle
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = STORE_RESET;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(Slots - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_kind)
                  REQ_BEGIN: begin
                     updating_in = 1'b1;
                  end
                  REQ_SET: begin
                     wr_en = updating_ff && (pixel_index < 16'(PIXELS)) &&
                             (channel != CH_NONE);
                  end
                  REQ_COMPLETE: begin
                     updating_in = 1'b0;
                     pos_in      = '0;
                  end
                  REQ_TICK: begin
                     if (!updating_ff && want != 4'd0 && stream_open) begin
                        remain_in = want;
                        state_in  = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            rd_en    = pos_in_store;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // read data stays put until the output register frees up
            if (!out_busy) begin
               out_load.load       = 1'b1;
               out_load.latch      = !pos_in_store;
               out_load.frame_last = pos_at_end;
               out_load.run_last   = pos_at_end || (remain_ff == 4'd1);
               pos_in              = pos_ff + 1'b1;
               remain_in           = remain_ff - 1'b1;
               state_in            = out_load.run_last ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         pos_ff      <= '0;
         remain_ff   <= '0;
         updating_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         pos_ff      <= pos_in;
         remain_ff   <= remain_in;
         updating_ff <= updating_in;
      end
   end

   // stream position never runs past the last latch byte
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosW'(StreamLen))
      else $error("stream position beyond end of frame");

   // a burst in flight always has bytes left to send
   a_remain_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_LOAD) |-> remain_ff != 4'd0)
      else $error("burst active with no bytes left");

   // reads and writes of the store never share a cycle
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store read and write in the same cycle");

   // a byte is only loaded while the stream is open and no update runs
   a_load_open: assert property (@(posedge clock) disable iff (reset)
      out_load.load |-> (stream_open && !updating_ff))
      else $error("byte loaded outside an open stream");

   // a fetch is always followed by the load state
   a_fetch_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |=> state_ff == ST_LOAD)
      else $error("fetch not followed by load");

endmodule

/* design/led_strip_frame_serializer.sv */
// led_strip_frame_serializer: top level, grb frame store streamed as spi bytes
// request unpacking, sequencer, frame store and the output register
// depends on lss_pkg, lss_ctrl, lss_frame_mem
//
// usage: requests arrive on the req_ channel; req_tuser carries the kind
// (begin update, set pixel, complete update, transmit tick). set pixel writes
// 0x80 | level>>1 into the green, red or blue byte of a pixel while an update
// is open. a transmit tick outside an update sends up to tx_free bytes (at most
// MAX_BURST and 8) on the rsp_ channel: the frame store, then LATCH_LEN zero
// latch bytes. rsp_tlast marks the last byte of a tick, rsp_tuser the final
// latch byte of the frame. complete update rewinds the stream to byte zero.
// non-tick requests and ticks that send nothing leave the sequencer idle. a
// tick sending bytes holds the request side through the transfer cycle, then
// per byte one fetch (a registered read of the frame store for store bytes)
// and one load of the output register; its first byte is valid once the first
// load is done. the next request is taken while the last byte of a tick still
// waits in the output register. when rsp_tready is low the sequencer holds the
// fetched byte and waits. after reset the store is cleared to 0x80, one entry
// per cycle, with req_tready low until all 3*PIXELS entries are written.
module led_strip_frame_serializer
   import lss_pkg::*;
#(
   parameter int PIXELS    = DefPixels,
   parameter int LATCH_LEN = DefLatchLen,
   parameter int MAX_BURST = DefMaxBurst
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] pixel_index, [17:16] channel, [25:18] level, [29:26] tx_free
   input  logic [31:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] tx_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // [0] frame_last
   output logic [0:0]  rsp_tuser
);

   localparam int Slots  = 3 * PIXELS;
   localparam int AddrW  = $clog2(Slots);

   out_load_type       out_load;
   logic               wr_en;
   logic [AddrW-1:0]   wr_addr;
   logic [7:0]         wr_data;
   logic               rd_en;
   logic [AddrW-1:0]   rd_addr;
   logic [7:0]         rd_data;
   logic               out_busy;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff;
   logic               rsp_frame_ff;

   assign out_busy = rsp_valid_ff && !rsp_tready;

   lss_ctrl #(
      .PIXELS    (PIXELS),
      .LATCH_LEN (LATCH_LEN),
      .MAX_BURST (MAX_BURST),
      .ADDR_W    (AddrW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_kind_type'(req_tuser)),
      .pixel_index (req_tdata[15:0]),
      .channel     (req_tdata[17:16]),
      .level       (req_tdata[25:18]),
      .tx_free     (req_tdata[29:26]),
      .out_busy    (out_busy),
      .out_load    (out_load),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   lss_frame_mem #(
      .DEPTH  (Slots),
      .ADDR_W (AddrW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load.load) begin
         rsp_byte_ff  <= out_load.latch ? LATCH_BYTE : rd_data;
         rsp_last_ff  <= out_load.run_last;
         rsp_frame_ff <= out_load.frame_last;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_byte_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_frame_ff;

endmodule
